// ===== hw/rtl/gda_pkg.sv =====
package gda_pkg;

  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int COUNT_W  = 16;
  localparam int GAP_W    = 22;
  localparam int CMD_W    = 2;
  localparam int REL_W    = 2;
  localparam int STAT_W   = 2;

  // internal year counter covers the whole parameter range
  localparam int YR_W     = 16;
  // day serial wide enough for the largest MAX_YEAR
  localparam int SER_W    = 25;
  localparam int YLEN_W   = 9;

  localparam int unsigned MAX_YEAR_DEF = 4095;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_SUB  = 2'd1,
    CMD_CMP  = 2'd2,
    CMD_DIFF = 2'd3
  } cmd_t;

  localparam logic [REL_W-1:0] REL_LT = 2'd0;
  localparam logic [REL_W-1:0] REL_EQ = 2'd1;
  localparam logic [REL_W-1:0] REL_GT = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic clear;
    logic step;
  } walk_ctrl_t;

endpackage

// ===== hw/rtl/gda_yrw.sv =====
module gda_yrw
  import gda_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  walk_ctrl_t          ctrl,
  input  logic [MONTH_W-1:0]  month,
  output logic [YR_W-1:0]     yr,
  output logic [YLEN_W-1:0]   year_len,
  output logic [DAY_W-1:0]    month_len
);

  logic [6:0] c100;
  logic [8:0] c400;
  logic       leap;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      yr   <= '0;
      c100 <= '0;
      c400 <= '0;
    end else if (ctrl.step) begin
      yr   <= yr + 1'b1;
      c100 <= (c100 == 7'd99)  ? 7'd0 : c100 + 1'b1;
      c400 <= (c400 == 9'd399) ? 9'd0 : c400 + 1'b1;
    end
  end

  assign leap     = ((yr[1:0] == 2'd0) && (c100 != 7'd0)) || (c400 == 9'd0);
  assign year_len = leap ? 9'd366 : 9'd365;

  always_comb begin
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      default:                 month_len = 5'd31;
    endcase
  end

  a_clear : assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (yr == '0) && (c100 == 7'd0) && (c400 == 9'd0))
    else $error("year walker did not clear");

  a_step : assert property (@(posedge clk) disable iff (rst)
    ctrl.step && !ctrl.clear |=> yr == $past(yr) + 1'b1)
    else $error("year walker missed a step");

  a_cycle : assert property (@(posedge clk) disable iff (rst)
    (c400 == 9'd0) |-> (c100 == 7'd0))
    else $error("century counters out of step");

endmodule

// ===== hw/rtl/gregorian_date_arithmetic.sv =====
// add and subtract walk the first date's years and months, then the result's years and
//   months; compare and difference walk the years and months of both dates in turn
// throughput: one word at a time, set by the year walker that steps one year a cycle
// the receiver cannot stall; each result is shown for one cycle with done
// reset returns the sequencer to idle at once, with no clearing pass
module gregorian_date_arithmetic
  import gda_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [CMD_W-1:0]          command,
  input  logic [YEAR_W-1:0]         first_year,
  input  logic [MONTH_W-1:0]        first_month,
  input  logic [DAY_W-1:0]          first_day,
  input  logic [YEAR_W-1:0]         second_year,
  input  logic [MONTH_W-1:0]        second_month,
  input  logic [DAY_W-1:0]          second_day,
  input  logic [COUNT_W-1:0]        day_count,
  output logic                      done,
  output logic [YEAR_W-1:0]         result_year,
  output logic [MONTH_W-1:0]        result_month,
  output logic [DAY_W-1:0]          result_day,
  output logic [REL_W-1:0]          relation,
  output logic signed [GAP_W-1:0]   day_gap,
  output logic [STAT_W-1:0]         status
);

  localparam logic [SER_W-1:0] LIMIT = SER_W'(365 * (MAX_YEAR + 1) + MAX_YEAR / 4
                                              - MAX_YEAR / 100 + MAX_YEAR / 400 + 1);
  localparam logic [YR_W-1:0]  MAX_YR = YR_W'(MAX_YEAR);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_YEAR   = 7'b0000010,
    S_MONTH  = 7'b0000100,
    S_SHIFT  = 7'b0001000,
    S_DYEAR  = 7'b0010000,
    S_DMONTH = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  cmd_t               cmd;
  logic [YEAR_W-1:0]  y1, y2;
  logic [MONTH_W-1:0] m1, m2;
  logic [DAY_W-1:0]   d1, d2;
  logic [COUNT_W-1:0] cnt;
  logic               sel;
  logic [SER_W-1:0]   acc, s1, s2;
  logic [MONTH_W-1:0] mon;

  walk_ctrl_t         wctrl;
  logic [YR_W-1:0]    yr;
  logic [YLEN_W-1:0]  year_len;
  logic [DAY_W-1:0]   month_len;

  logic [YEAR_W-1:0]  cy;
  logic [MONTH_W-1:0] cm;
  logic [DAY_W-1:0]   cd;
  logic               ok1, ok2, pre_ok;
  logic [SER_W-1:0]   serial, sum, s_diff;

  gda_yrw u_yrw (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (wctrl),
    .month     (mon),
    .yr        (yr),
    .year_len  (year_len),
    .month_len (month_len)
  );

  // coarse date checks; the day limit waits for the walk
  assign ok1 = (YR_W'(first_year) <= MAX_YR) && (first_month >= 4'd1)
               && (first_month <= 4'd12) && (first_day != '0);
  assign ok2 = (YR_W'(second_year) <= MAX_YR) && (second_month >= 4'd1)
               && (second_month <= 4'd12) && (second_day != '0);
  assign pre_ok = ok1 && ((command == CMD_ADD) || (command == CMD_SUB) || ok2);

  assign cy = sel ? y2 : y1;
  assign cm = sel ? m2 : m1;
  assign cd = sel ? d2 : d1;

  assign serial = acc + SER_W'(cd) - 1'b1;
  assign sum    = s1 + SER_W'(cnt);
  assign s_diff = s1 - s2;

  always_comb begin
    state_next  = state;
    wctrl.clear = 1'b0;
    wctrl.step  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next  = pre_ok ? S_YEAR : S_DONE;
          wctrl.clear = 1'b1;
        end
      end
      S_YEAR: begin
        if (yr == YR_W'(cy)) begin
          state_next = S_MONTH;
        end else begin
          wctrl.step = 1'b1;
        end
      end
      S_MONTH: begin
        if (mon == cm) begin
          if (cd > month_len) begin
            state_next = S_DONE;
          end else if (!sel && ((cmd == CMD_CMP) || (cmd == CMD_DIFF))) begin
            state_next  = S_YEAR;
            wctrl.clear = 1'b1;
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        wctrl.clear = 1'b1;
        if ((cmd == CMD_ADD) && (sum < LIMIT)) begin
          state_next = S_DYEAR;
        end else if ((cmd == CMD_SUB) && (SER_W'(cnt) <= s1)) begin
          state_next = S_DYEAR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DYEAR: begin
        if (acc >= SER_W'(year_len)) begin
          wctrl.step = 1'b1;
        end else begin
          state_next = S_DMONTH;
        end
      end
      S_DMONTH: begin
        if ((mon >= 4'd12) || (acc < SER_W'(month_len))) begin
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd          <= cmd_t'(command);
          y1           <= first_year;
          m1           <= first_month;
          d1           <= first_day;
          y2           <= second_year;
          m2           <= second_month;
          d2           <= second_day;
          cnt          <= day_count;
          sel          <= 1'b0;
          acc          <= '0;
          mon          <= 4'd1;
          result_year  <= '0;
          result_month <= 4'd1;
          result_day   <= 5'd1;
          relation     <= REL_LT;
          day_gap      <= '0;
          status       <= pre_ok ? ST_OK : ST_INVALID;
        end
      end
      S_YEAR: begin
        if (yr != YR_W'(cy)) begin
          acc <= acc + SER_W'(year_len);
        end
      end
      S_MONTH: begin
        if (mon == cm) begin
          if (cd > month_len) begin
            status <= ST_INVALID;
          end else if (!sel) begin
            s1  <= serial;
            sel <= 1'b1;
            acc <= '0;
            mon <= 4'd1;
          end else begin
            s2 <= serial;
          end
        end else begin
          acc <= acc + SER_W'(month_len);
          mon <= mon + 1'b1;
        end
      end
      S_SHIFT: begin
        mon <= 4'd1;
        case (cmd)
          CMD_ADD: begin
            if (sum < LIMIT) acc <= sum;
            else status <= ST_RANGE;
          end
          CMD_SUB: begin
            if (SER_W'(cnt) <= s1) acc <= s1 - SER_W'(cnt);
            else status <= ST_RANGE;
          end
          default: begin
            relation <= (s1 < s2) ? REL_LT : ((s1 == s2) ? REL_EQ : REL_GT);
            if (cmd == CMD_DIFF) day_gap <= s_diff[GAP_W-1:0];
          end
        endcase
      end
      S_DYEAR: begin
        if (acc >= SER_W'(year_len)) begin
          acc <= acc - SER_W'(year_len);
        end
      end
      S_DMONTH: begin
        if ((mon >= 4'd12) || (acc < SER_W'(month_len))) begin
          result_year  <= yr[YEAR_W-1:0];
          result_month <= mon;
          result_day   <= acc[DAY_W-1:0] + 1'b1;
        end else begin
          acc <= acc - SER_W'(month_len);
          mon <= mon + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  a_take : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("word taken but unit not busy");

  a_fail_date : assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |->
      (result_year == '0) && (result_month == 4'd1) && (result_day == 5'd1))
    else $error("failed word carries a date");

  a_shift_rel : assert property (@(posedge clk) disable iff (rst)
    done && ((cmd == CMD_ADD) || (cmd == CMD_SUB)) |->
      (relation == REL_LT) && (day_gap == '0))
    else $error("date shift word carries a relation");

endmodule

// ===== bench/tb_gregorian_date_arithmetic.sv =====
`timescale 1ns / 1ps

module tb_gregorian_date_arithmetic;
  import gda_pkg::*;

  localparam int RANDOM_WORDS = 115;
  localparam int DRAIN_AT     = 70;
  localparam int IDLE_LIMIT   = 40000;
  localparam int SETTLE       = 40;

  typedef struct packed {
    cmd_t               command;
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic [COUNT_W-1:0] day_count;
  } date_word_t;

  typedef struct packed {
    logic [YEAR_W-1:0]       year;
    logic [MONTH_W-1:0]      month;
    logic [DAY_W-1:0]        day;
    logic [REL_W-1:0]        relation;
    logic signed [GAP_W-1:0] gap;
    logic [STAT_W-1:0]       status;
  } date_answer_t;

  typedef struct packed {
    date_word_t   word;
    logic         typed;
    date_answer_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t command = CMD_ADD;
  logic [YEAR_W-1:0] first_year = '0;
  logic [MONTH_W-1:0] first_month = '0;
  logic [DAY_W-1:0] first_day = '0;
  logic [YEAR_W-1:0] second_year = '0;
  logic [MONTH_W-1:0] second_month = '0;
  logic [DAY_W-1:0] second_day = '0;
  logic [COUNT_W-1:0] day_count = '0;
  logic done;
  logic [YEAR_W-1:0] result_year;
  logic [MONTH_W-1:0] result_month;
  logic [DAY_W-1:0] result_day;
  logic [REL_W-1:0] relation;
  logic signed [GAP_W-1:0] day_gap;
  logic [STAT_W-1:0] status;

  logic typed_flag = 1'b0;
  date_answer_t typed_want = '0;

  date_answer_t answers_due[$];
  stim_row_t directed_rows[$];
  int fail_count = 0;
  int results_checked = 0;
  int invalid_seen = 0;
  int range_seen = 0;
  int cmd_words[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;

  gregorian_date_arithmetic dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .first_year(first_year),
    .first_month(first_month),
    .first_day(first_day),
    .second_year(second_year),
    .second_month(second_month),
    .second_day(second_day),
    .day_count(day_count),
    .done(done),
    .result_year(result_year),
    .result_month(result_month),
    .result_day(result_day),
    .relation(relation),
    .day_gap(day_gap),
    .status(status)
  );

  always #5 clk = ~clk;

  function automatic bit leap_year(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_length(int y, int m);
    case (m)
      2: begin
        return leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      1, 3, 5, 7, 8, 10, 12: begin
        return 31;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  // days from 1 jan of year 0 to 1 jan of year y
  function automatic int days_to_year(int y);
    int p;
    if (y == 0) return 0;
    p = y - 1;
    return 365 * y + p / 4 - p / 100 + p / 400 + 1;
  endfunction

  function automatic bit date_ok(int y, int m, int d);
    return y <= int'(MAX_YEAR_DEF) && m >= 1 && m <= 12 && d >= 1 &&
           d <= month_length(y, m);
  endfunction

  function automatic int day_number(int y, int m, int d);
    int s;
    s = days_to_year(y);
    for (int k = 1; k < m; k++) s += month_length(y, k);
    return s + d - 1;
  endfunction

  function automatic void date_from_number(input int s, output int y, output int m,
                                           output int d);
    int r;
    y = s / 366;
    while (days_to_year(y + 1) <= s) y++;
    r = s - days_to_year(y);
    m = 1;
    while (m < 12 && r >= month_length(y, m)) begin
      r -= month_length(y, m);
      m++;
    end
    d = r + 1;
  endfunction

  function automatic date_answer_t mk_want(int y, int m, int d, logic [REL_W-1:0] rel,
                                           int gap, logic [STAT_W-1:0] st);
    date_answer_t a;
    a.year = YEAR_W'(y);
    a.month = MONTH_W'(m);
    a.day = DAY_W'(d);
    a.relation = rel;
    a.gap = GAP_W'(gap);
    a.status = st;
    return a;
  endfunction

  function automatic date_answer_t date_unit_answer(date_word_t w);
    date_answer_t a;
    int s1, s2, y, m, d;
    a = mk_want(0, 1, 1, REL_LT, 0, ST_OK);
    if (w.command == CMD_ADD || w.command == CMD_SUB) begin
      if (!date_ok(int'(w.first_year), int'(w.first_month), int'(w.first_day))) begin
        a.status = ST_INVALID;
      end else begin
        s1 = day_number(int'(w.first_year), int'(w.first_month), int'(w.first_day));
        if (w.command == CMD_ADD) begin
          s1 += int'(w.day_count);
          if (s1 >= days_to_year(int'(MAX_YEAR_DEF) + 1)) a.status = ST_RANGE;
        end else if (int'(w.day_count) > s1) begin
          a.status = ST_RANGE;
        end else begin
          s1 -= int'(w.day_count);
        end
        if (a.status == ST_OK) begin
          date_from_number(s1, y, m, d);
          a.year = YEAR_W'(y);
          a.month = MONTH_W'(m);
          a.day = DAY_W'(d);
        end
      end
    end else begin
      if (!date_ok(int'(w.first_year), int'(w.first_month), int'(w.first_day)) ||
          !date_ok(int'(w.second_year), int'(w.second_month), int'(w.second_day))) begin
        a.status = ST_INVALID;
      end else begin
        s1 = day_number(int'(w.first_year), int'(w.first_month), int'(w.first_day));
        s2 = day_number(int'(w.second_year), int'(w.second_month), int'(w.second_day));
        a.relation = (s1 < s2) ? REL_LT : (s1 == s2) ? REL_EQ : REL_GT;
        if (w.command == CMD_DIFF) a.gap = GAP_W'(s1 - s2);
      end
    end
    return a;
  endfunction

  function automatic stim_row_t mk_row(cmd_t c, int y1, int m1, int d1, int y2, int m2,
                                       int d2, int cnt, logic typed, date_answer_t want);
    stim_row_t r;
    r.word.command = c;
    r.word.first_year = YEAR_W'(y1);
    r.word.first_month = MONTH_W'(m1);
    r.word.first_day = DAY_W'(d1);
    r.word.second_year = YEAR_W'(y2);
    r.word.second_month = MONTH_W'(m2);
    r.word.second_day = DAY_W'(d2);
    r.word.day_count = COUNT_W'(cnt);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic int random_year();
    int pick;
    pick = int'($urandom_range(0, 99));
    if (pick < 25) return int'($urandom_range(0, 20));
    if (pick < 45) return int'($urandom_range(MAX_YEAR_DEF - 20, MAX_YEAR_DEF));
    return int'($urandom_range(0, MAX_YEAR_DEF));
  endfunction

  function automatic void random_date(output logic [YEAR_W-1:0] y,
                                      output logic [MONTH_W-1:0] m,
                                      output logic [DAY_W-1:0] d);
    int yy, mm;
    if ($urandom_range(0, 99) < 12) begin
      y = YEAR_W'($urandom_range(0, MAX_YEAR_DEF));
      m = MONTH_W'($urandom_range(0, 15));
      d = DAY_W'($urandom_range(0, 31));
    end else begin
      yy = random_year();
      mm = int'($urandom_range(1, 12));
      y = YEAR_W'(yy);
      m = MONTH_W'(mm);
      d = DAY_W'($urandom_range(1, month_length(yy, mm)));
    end
  endfunction

  function automatic date_word_t random_word();
    date_word_t w;
    logic [1:0] c;
    int pick;
    int mm;
    c = 2'($urandom_range(0, 3));
    w.command = cmd_t'(c);
    random_date(w.first_year, w.first_month, w.first_day);
    pick = int'($urandom_range(0, 99));
    if (pick < 20) begin
      w.second_year = w.first_year;
      w.second_month = w.first_month;
      w.second_day = w.first_day;
    end else if (pick < 40) begin
      mm = int'($urandom_range(1, 12));
      w.second_year = w.first_year;
      w.second_month = MONTH_W'(mm);
      w.second_day = DAY_W'($urandom_range(1, month_length(int'(w.first_year), mm)));
    end else begin
      random_date(w.second_year, w.second_month, w.second_day);
    end
    pick = int'($urandom_range(0, 99));
    if (pick < 40) w.day_count = COUNT_W'($urandom_range(0, 400));
    else if (pick < 60) w.day_count = COUNT_W'($urandom_range(0, 3000));
    else if (pick < 70) w.day_count = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    else w.day_count = COUNT_W'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = int'($urandom_range(0, 99));
    if (pick < 60) return 0;
    if (pick < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  task automatic send_word(date_word_t w, logic typed, date_answer_t want);
    start <= 1'b1;
    command <= w.command;
    first_year <= w.first_year;
    first_month <= w.first_month;
    first_day <= w.first_day;
    second_year <= w.second_year;
    second_month <= w.second_month;
    second_day <= w.second_day;
    day_count <= w.day_count;
    typed_flag <= typed;
    typed_want <= want;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : monitor
    date_answer_t due;
    date_word_t seen;
    if (!rst) begin
      if (done) begin
        if (answers_due.size() == 0) begin
          $error("result word with nothing outstanding");
          fail_count++;
        end else begin
          due = answers_due.pop_front();
          results_checked++;
          if (status == ST_INVALID) invalid_seen++;
          if (status == ST_RANGE) range_seen++;
          if (result_year !== due.year) begin
            $error("result_year: expected %0d, actual %0d", due.year, result_year);
            fail_count++;
          end
          if (result_month !== due.month) begin
            $error("result_month: expected %0d, actual %0d", due.month, result_month);
            fail_count++;
          end
          if (result_day !== due.day) begin
            $error("result_day: expected %0d, actual %0d", due.day, result_day);
            fail_count++;
          end
          if (relation !== due.relation) begin
            $error("relation: expected %0d, actual %0d", due.relation, relation);
            fail_count++;
          end
          if (day_gap !== due.gap) begin
            $error("day_gap: expected %0d, actual %0d", due.gap, day_gap);
            fail_count++;
          end
          if (status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, status);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        seen.command = command;
        seen.first_year = first_year;
        seen.first_month = first_month;
        seen.first_day = first_day;
        seen.second_year = second_year;
        seen.second_month = second_month;
        seen.second_day = second_day;
        seen.day_count = day_count;
        answers_due.push_back(typed_flag ? typed_want : date_unit_answer(seen));
        cmd_words[command]++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    date_answer_t none;
    none = '0;
    // every error row and some of the others carry a typed answer, the rest go through the predictor
    directed_rows.push_back(mk_row(CMD_ADD, 0, 1, 1, 0, 1, 1, 0, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_OK)));
    directed_rows.push_back(mk_row(CMD_ADD, 4095, 12, 31, 0, 1, 1, 0, 1'b1,
                                   mk_want(4095, 12, 31, REL_LT, 0, ST_OK)));
    directed_rows.push_back(mk_row(CMD_ADD, 4095, 12, 31, 0, 1, 1, 1, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_RANGE)));
    directed_rows.push_back(mk_row(CMD_SUB, 0, 1, 1, 0, 1, 1, 0, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_OK)));
    directed_rows.push_back(mk_row(CMD_SUB, 0, 1, 1, 0, 1, 1, 1, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_RANGE)));
    directed_rows.push_back(mk_row(CMD_ADD, 0, 1, 1, 0, 1, 1, 65535, 1'b0, none));
    directed_rows.push_back(mk_row(CMD_SUB, 4095, 12, 31, 0, 1, 1, 65535, 1'b0, none));
    directed_rows.push_back(mk_row(CMD_ADD, 2000, 0, 10, 0, 1, 1, 5, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_INVALID)));
    directed_rows.push_back(mk_row(CMD_SUB, 2000, 13, 10, 0, 1, 1, 5, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_INVALID)));
    directed_rows.push_back(mk_row(CMD_ADD, 4095, 15, 31, 0, 1, 1, 5, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_INVALID)));
    directed_rows.push_back(mk_row(CMD_ADD, 2001, 4, 31, 0, 1, 1, 5, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_INVALID)));
    directed_rows.push_back(mk_row(CMD_SUB, 2001, 5, 0, 0, 1, 1, 5, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_INVALID)));
    directed_rows.push_back(mk_row(CMD_ADD, 1900, 2, 29, 0, 1, 1, 1, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_INVALID)));
    directed_rows.push_back(mk_row(CMD_ADD, 2100, 2, 29, 0, 1, 1, 1, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_INVALID)));
    directed_rows.push_back(mk_row(CMD_ADD, 2000, 2, 29, 0, 1, 1, 1, 1'b0, none));
    directed_rows.push_back(mk_row(CMD_SUB, 2400, 3, 1, 0, 1, 1, 1, 1'b0, none));
    directed_rows.push_back(mk_row(CMD_ADD, 0, 2, 28, 0, 1, 1, 1, 1'b0, none));
    directed_rows.push_back(mk_row(CMD_ADD, 1999, 12, 31, 0, 1, 1, 1, 1'b0, none));
    directed_rows.push_back(mk_row(CMD_SUB, 2001, 1, 1, 0, 1, 1, 1, 1'b0, none));
    directed_rows.push_back(mk_row(CMD_CMP, 2024, 2, 29, 2024, 2, 29, 0, 1'b1,
                                   mk_want(0, 1, 1, REL_EQ, 0, ST_OK)));
    directed_rows.push_back(mk_row(CMD_CMP, 1, 1, 1, 4095, 12, 31, 0, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_OK)));
    directed_rows.push_back(mk_row(CMD_CMP, 4095, 12, 31, 0, 1, 1, 0, 1'b1,
                                   mk_want(0, 1, 1, REL_GT, 0, ST_OK)));
    directed_rows.push_back(mk_row(CMD_DIFF, 4095, 12, 31, 0, 1, 1, 0, 1'b0, none));
    directed_rows.push_back(mk_row(CMD_DIFF, 0, 1, 1, 4095, 12, 31, 0, 1'b0, none));
    directed_rows.push_back(mk_row(CMD_DIFF, 2020, 6, 15, 2023, 2, 29, 0, 1'b1,
                                   mk_want(0, 1, 1, REL_LT, 0, ST_INVALID)));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      hold_off(gap_len());
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_word(random_word(), 1'b0, none);
      if (n == DRAIN_AT) begin
        // let every outstanding word come back before carrying on
        start <= 1'b0;
        do @(posedge clk); while (answers_due.size() != 0);
      end else if (n >= 30 && n < 45) begin
        // back-to-back stretch
      end else begin
        hold_off(gap_len());
      end
    end
    start <= 1'b0;

    do @(posedge clk); while (answers_due.size() != 0);
    repeat (SETTLE) @(posedge clk);

    $display("words sent: %0d add, %0d subtract, %0d compare, %0d difference; %0d checked",
             cmd_words[CMD_ADD], cmd_words[CMD_SUB], cmd_words[CMD_CMP], cmd_words[CMD_DIFF],
             results_checked);
    $display("%0d invalid-date and %0d year-out-of-range results, one full drain mid-run",
             invalid_seen, range_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
